// ===== rtl/core/tws_pkg.sv =====
// Package for the timing wheel scheduler: field widths and command codes.
// No dependencies; used by the channel interfaces and the top level.
package tws_pkg;

  localparam int TIMER_ID_W = 4;
  localparam int PERIOD_W   = 10;
  localparam int CMD_W      = 2;

  // Code three is unused and is ignored by the block.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DEL  = 2'd2
  } cmd_t;

endpackage

// ===== rtl/core/tws_in_if.sv =====
// Command channel of the timing wheel scheduler: valid/ready plus one command beat.
// Depends on tws_pkg.
interface tws_in_if;
  import tws_pkg::*;

  logic                  valid;
  logic                  ready;
  cmd_t                  command;
  logic [TIMER_ID_W-1:0] timer_id;
  logic [PERIOD_W-1:0]   period_ticks;

  modport source (output valid, command, timer_id, period_ticks, input ready);
  modport sink   (input valid, command, timer_id, period_ticks, output ready);
endinterface

// ===== rtl/core/tws_out_if.sv =====
// Result channel of the timing wheel scheduler: valid/ready plus one fired-timer beat.
// Depends on tws_pkg.
interface tws_out_if;
  import tws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TIMER_ID_W-1:0] fired_id;
  logic                  last_fired;

  modport source (output valid, fired_id, last_fired, input ready);
  modport sink   (input valid, fired_id, last_fired, output ready);
endinterface

// ===== rtl/core/tws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== rtl/core/timing_wheel_scheduler_top.sv =====
// Hashed timing wheel of periodic timers, top level.
// Depends on tws_pkg, tws_in_if, tws_out_if and tws_ram.
//
// Usage:
//  - in_if carries command beats: tick, add (arm or re-arm timer_id with
//    period_ticks) and delete. A beat is taken when valid and ready are high.
//  - out_if carries one beat per timer that fires on a tick, in ascending id
//    order; last_fired marks the final beat of that tick. A tick that fires
//    nothing produces no beat.
//  - Steps: delete clears the armed bit on acceptance; add does a reciprocal
//    multiply, then an entry write. A tick: accept, first RAM read, one entry
//    per cycle while not stalled (modified and written back while the next
//    is read), then a closing step that hands off the last fired id.
//  - ready is high only between commands; the block works on one command at
//    a time.
//  - Reset (rst_n low, synchronous) disarms all timers, puts the wheel at
//    slot zero and empties the output register. No RAM clearing pass is
//    needed: an entry is acted on only while its armed bit is set.
//  - A stalled receiver holds the output register; the sweep pauses when a
//    new fired id finds both the output register and the pending id full.
module timing_wheel_scheduler_top #(
  parameter int WHEEL_SLOTS = 10,
  parameter int MAX_TIMERS  = 16,
  parameter int PERIOD_BITS = 10
) (
  input logic       clk,
  input logic       rst_n,
  tws_in_if.sink    in_if,
  tws_out_if.source out_if
);
  import tws_pkg::*;

  // Stored period width: the input field caps it.
  localparam int PW    = (PERIOD_BITS < PERIOD_W) ? PERIOD_BITS : PERIOD_W;
  localparam int SW    = $clog2(WHEEL_SLOTS);
  localparam int IW    = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW    = $clog2(MAX_TIMERS + 1);
  localparam int RMAX  = ((1 << PW) - 2) / WHEEL_SLOTS;
  localparam int RW    = (RMAX > 0) ? $clog2(RMAX + 1) : 1;
  localparam int XW    = ((PW > SW) ? PW : SW) + 1;
  // floor(x / WHEEL_SLOTS) = (x * RECIP) >> SH, exact for x < 2**PW.
  localparam int SH    = PW + $clog2(WHEEL_SLOTS);
  localparam int RECIP = ((1 << SH) + WHEEL_SLOTS - 1) / WHEEL_SLOTS;
  localparam int MW    = PW + 2;
  localparam int EW    = 2 * SW + 2 * RW;

  // Per-timer RAM entry. offset = period mod slots, reload = (period-1)/slots,
  // precomputed at add time so a re-arm during a tick needs no divide.
  typedef struct packed {
    logic [SW-1:0] slot;
    logic [RW-1:0] rounds;
    logic [SW-1:0] offset;
    logic [RW-1:0] reload;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WR   = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= (SW+1)'(WHEEL_SLOTS)) ? SW'(s - (SW+1)'(WHEEL_SLOTS)) : SW'(s);
  endfunction

  state_t                 state_r, state_nxt;
  logic [SW-1:0]          cur_r, cur_nxt;
  logic [MAX_TIMERS-1:0]  armed_r, armed_nxt;
  logic [IW-1:0]          arm_id_r, arm_id_nxt;
  logic [PW-1:0]          arm_x_r, arm_x_nxt;
  logic [PW+MW-1:0]       prod_r, prod_nxt;
  logic [CW-1:0]          scan_addr_r, scan_addr_nxt;
  logic                   exam_v_r, exam_v_nxt;
  logic [IW-1:0]          exam_idx_r, exam_idx_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [IW-1:0]          pend_id_r, pend_id_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TIMER_ID_W-1:0]  out_id_r, out_id_nxt;
  logic                   out_last_r, out_last_nxt;

  // RAM port signals
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_wa, ram_ra;
  entry_t        ram_wd, ent;
  logic [EW-1:0] ram_rd;

  // Add path, entry-write state
  logic [PW-1:0] q, q_fix;
  logic [XW-1:0] qw, rem_raw, rem_fix;
  logic          corr;
  logic [SW-1:0] add_off;
  logic [RW-1:0] add_reload;

  // Command decode
  logic          accept, id_ok;
  logic [PW-1:0] p_m, p_eff;

  // Sweep
  logic hit, fire, stall, done, out_free, push, push_last;

  tws_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TIMERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign ent = entry_t'(ram_rd);

  assign accept   = in_if.valid && in_if.ready;
  assign id_ok    = (32'(in_if.timer_id) < 32'(MAX_TIMERS));
  assign p_m      = PW'(in_if.period_ticks);
  assign p_eff    = (p_m == '0) ? PW'(1) : p_m;
  assign out_free = !out_valid_r || out_if.ready;

  // Quotient correction is a safety net; the reciprocal is exact over range.
  assign q          = PW'(prod_r >> SH);
  assign qw         = XW'(q) * XW'(WHEEL_SLOTS);
  assign rem_raw    = XW'(arm_x_r) - qw;
  assign corr       = (rem_raw >= XW'(WHEEL_SLOTS));
  assign q_fix      = corr ? q + 1'b1 : q;
  assign rem_fix    = corr ? rem_raw - XW'(WHEEL_SLOTS) : rem_raw;
  assign add_reload = RW'(q_fix);
  // period mod slots = ((period-1) mod slots) + 1, wrapped
  assign add_off    = (rem_fix == XW'(WHEEL_SLOTS - 1)) ? '0 : SW'(rem_fix + 1'b1);

  assign hit  = exam_v_r && armed_r[exam_idx_r] && (ent.slot == cur_r);
  assign fire = hit && (ent.rounds == '0);
  // A second fired id needs the pending one moved out first.
  assign stall = fire && pend_v_r && !out_free;
  assign done  = !exam_v_r && (scan_addr_r == CW'(MAX_TIMERS));

  assign in_if.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    armed_nxt     = armed_r;
    arm_id_nxt    = arm_id_r;
    arm_x_nxt     = arm_x_r;
    prod_nxt      = prod_r;
    scan_addr_nxt = scan_addr_r;
    exam_v_nxt    = exam_v_r;
    exam_idx_nxt  = exam_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    push          = 1'b0;
    push_last     = 1'b0;
    ram_we        = 1'b0;
    ram_wa        = exam_idx_r;
    ram_wd        = ent;
    ram_re        = 1'b0;
    ram_ra        = scan_addr_r[IW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_if.command)
            CMD_TICK: begin
              cur_nxt       = (cur_r == SW'(WHEEL_SLOTS - 1)) ? '0 : cur_r + 1'b1;
              scan_addr_nxt = '0;
              exam_v_nxt    = 1'b0;
              pend_v_nxt    = 1'b0;
              state_nxt     = ST_SCAN;
            end
            CMD_ADD: begin
              if (id_ok) begin
                arm_id_nxt = IW'(in_if.timer_id);
                arm_x_nxt  = p_eff - 1'b1;
                prod_nxt   = (PW+MW)'(p_eff - 1'b1) * (PW+MW)'(RECIP);
                state_nxt  = ST_WR;
              end
            end
            CMD_DEL: begin
              if (id_ok) begin
                armed_nxt[IW'(in_if.timer_id)] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WR: begin
        ram_we            = 1'b1;
        ram_wa            = arm_id_r;
        ram_wd.slot       = wrap_add(cur_r, add_off);
        ram_wd.rounds     = add_reload;
        ram_wd.offset     = add_off;
        ram_wd.reload     = add_reload;
        armed_nxt[arm_id_r] = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_SCAN: begin
        if (done) begin
          if (pend_v_r) begin
            if (out_free) begin
              push       = 1'b1;
              push_last  = 1'b1;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (!stall) begin
          if (fire) begin
            // fire and re-arm with the stored period
            ram_we        = 1'b1;
            ram_wd.slot   = wrap_add(cur_r, ent.offset);
            ram_wd.rounds = ent.reload;
            push          = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_id_nxt   = exam_idx_r;
          end else if (hit) begin
            ram_we        = 1'b1;
            ram_wd.rounds = ent.rounds - 1'b1;
          end
          if (scan_addr_r < CW'(MAX_TIMERS)) begin
            ram_re        = 1'b1;
            exam_v_nxt    = 1'b1;
            exam_idx_nxt  = scan_addr_r[IW-1:0];
            scan_addr_nxt = scan_addr_r + 1'b1;
          end else begin
            exam_v_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = TIMER_ID_W'(pend_id_r);
      out_last_nxt  = push_last;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.fired_id   = out_id_r;
  assign out_if.last_fired = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      armed_r     <= '0;
      scan_addr_r <= '0;
      exam_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      armed_r     <= armed_nxt;
      scan_addr_r <= scan_addr_nxt;
      exam_v_r    <= exam_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arm_id_r   <= arm_id_nxt;
    arm_x_r    <= arm_x_nxt;
    prod_r     <= prod_nxt;
    exam_idx_r <= exam_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // Write-back and the next sweep read never target the same entry.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_wa != ram_ra))
    else $error("RAM read and write hit the same entry");

  // A held fired id never survives past the end of its tick.
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> !pend_v_r)
    else $error("pending fired id outside a tick sweep");

  // The final beat of a tick leaves the sweep done.
  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_last) |=> (state_r == ST_IDLE))
    else $error("last beat pushed before the sweep ended");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_addr_r <= CW'(MAX_TIMERS)))
    else $error("sweep address beyond table");
`endif
endmodule
